// ===== hdl/annb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// annb_pkg: shared types and constants of the Annex B NAL unit splitter
// Holds the command word passed from the parser to the emitter, the head
// tracking state, and the functions that apply one payload byte or the end
// of a NAL unit to that state.
// ----------------------------------------------------------------------------
package annb_pkg;

  // Leading store size: default and upper bound of the allowed range.
  localparam int unsigned LEAD_BYTES_DEF = 48;
  localparam int unsigned LEAD_BYTES_MAX = 60;
  localparam int unsigned LEAD_CNT_W     = $clog2(LEAD_BYTES_MAX + 1);

  // At most six result bytes come out of one streamed input byte.
  localparam int unsigned RES_SLOTS = 6;
  localparam int unsigned SLOT_W    = $clog2(RES_SLOTS + 1);

  // Depth of the command queue between parser and emitter (power of two).
  localparam int unsigned QDEPTH = 4;

  // Unregistered user data SEI: NAL header byte and payload type.
  localparam logic [7:0] SEI_NAL_BYTE = 8'h4e;
  localparam logic [7:0] SEI_UNREG    = 8'h05;

  // One result byte of a NAL unit.
  typedef struct packed {
    logic [7:0] data;
    logic       first;
    logic       last;
  } res_t;

  // Bytes of the current NAL unit held back until the SEI test is settled.
  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] b1;
    logic [1:0] cnt;
    logic       passing;
    logic       dropping;
  } head_t;

  // Outcome of one head update: new state and up to two result bytes.
  typedef struct packed {
    head_t      h;
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } commit_t;

  // Work for the emitter caused by one input word.
  typedef struct packed {
    logic [31:0]                tag;
    logic [SLOT_W-1:0]          n;
    res_t [RES_SLOTS-1:0]       slots;
    logic                       flush;
    logic [LEAD_CNT_W-1:0]      fcnt;
    logic                       fovf;
  } cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SLOTS,
    BK_FLUSH
  } back_state_t;

  // Add one payload byte to the current NAL unit.
  function automatic commit_t head_commit(head_t h, logic [7:0] b);
    commit_t c;
    c    = '0;
    c.h  = h;
    if (!h.dropping) begin
      if (h.passing) begin
        // Pass the held byte on and hold the new one.
        c.n  = 2'd1;
        c.r0 = '{data: h.b0, first: 1'b0, last: 1'b0};
        c.h.b0 = b;
      end else if (h.cnt == 2'd0) begin
        c.h.b0  = b;
        c.h.cnt = 2'd1;
      end else if (h.cnt == 2'd1) begin
        c.h.b1  = b;
        c.h.cnt = 2'd2;
      end else begin
        // Third byte settles whether the unit is unregistered SEI.
        if (h.b0 == SEI_NAL_BYTE && b == SEI_UNREG) begin
          c.h.dropping = 1'b1;
          c.h.cnt      = 2'd0;
        end else begin
          c.h.passing = 1'b1;
          c.n  = 2'd2;
          c.r0 = '{data: h.b0, first: 1'b1, last: 1'b0};
          c.r1 = '{data: h.b1, first: 1'b0, last: 1'b0};
          c.h.b0  = b;
          c.h.cnt = 2'd1;
        end
      end
    end
    return c;
  endfunction

  // Close the current NAL unit: release what is held, then clear.
  function automatic commit_t head_end(head_t h);
    commit_t c;
    c = '0;
    if (h.passing) begin
      c.n  = 2'd1;
      c.r0 = '{data: h.b0, first: 1'b0, last: 1'b1};
    end else if (!h.dropping) begin
      if (h.cnt == 2'd1) begin
        c.n  = 2'd1;
        c.r0 = '{data: h.b0, first: 1'b1, last: 1'b1};
      end else if (h.cnt == 2'd2) begin
        c.n  = 2'd2;
        c.r0 = '{data: h.b0, first: 1'b1, last: 1'b0};
        c.r1 = '{data: h.b1, first: 1'b0, last: 1'b1};
      end
    end
    return c;
  endfunction

endpackage

// ===== hdl/annb_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// annb_in_if: bitstream byte channel
// One word is one buffer byte with its end-of-buffer mark and frame tag.
// ----------------------------------------------------------------------------
interface annb_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic        end_of_buffer;
  logic [31:0] frame_tag;

  modport source (output valid, output data_byte, output end_of_buffer,
                  output frame_tag, input ready);
  modport sink   (input valid, input data_byte, input end_of_buffer,
                  input frame_tag, output ready);
endinterface

// ===== hdl/annb_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// annb_out_if: NAL unit byte channel
// One word is one NAL payload byte with its marks and frame tag.
// ----------------------------------------------------------------------------
interface annb_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  nal_byte;
  logic        nal_first;
  logic        nal_last;
  logic [31:0] nal_frame;
  logic        lead_overflow;
  logic        step_last;

  modport source (output valid, output nal_byte, output nal_first, output nal_last,
                  output nal_frame, output lead_overflow, output step_last,
                  input ready);
  modport sink   (input valid, input nal_byte, input nal_first, input nal_last,
                  input nal_frame, input lead_overflow, input step_last,
                  output ready);
endinterface

// ===== hdl/annexb_nal_splitter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// annexb_nal_splitter: Annex B NAL unit splitter
// Splits an HEVC Annex B byte stream into NAL units with start codes removed.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch takes one buffer byte per word with end_of_buffer on the last byte
//   and the frame tag of the buffer. out_ch gives NAL payload bytes with
//   first/last marks, the frame tag, the leading overflow flag and step_last
//   on the final result word caused by one input word.
//   Throughput: one input word per cycle while each byte causes at most one
//   result and out_ch takes every word; a byte that releases several bytes
//   occupies the emitter until all are sent, and a four-entry command queue
//   absorbs short bursts. Results pass the queue, the emitter command register
//   and the output register; the SEI test holds the first bytes of a unit.
//   A buffer without any start code is read back from the leading store at
//   one byte per cycle; input is held off until that readout is finished.
//   Reset clears the parser, the queue and the output stage; the leading
//   store needs no clearing since only bytes of the current buffer are read.
//   When the receiver stalls, the output word holds, the queue fills and
//   in_ch.ready drops once the queue is full.
// ----------------------------------------------------------------------------
module annexb_nal_splitter import annb_pkg::*; #(
  parameter int unsigned LEAD_BYTES = LEAD_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  annb_in_if.sink    in_ch,
  annb_out_if.source out_ch
);

  localparam int unsigned LEAD_AW = $clog2(LEAD_BYTES);

  logic               q_full;
  logic               q_empty;
  logic               push;
  logic               pop;
  cmd_t               push_cmd;
  cmd_t               head_cmd;
  logic               wr_en;
  logic [LEAD_AW-1:0] wr_addr;
  logic [7:0]         wr_data;
  logic               flush_done;

  // Parser: classifies bytes and builds command words.
  annb_front #(
    .LEAD_BYTES (LEAD_BYTES)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_ch      (in_ch),
    .q_full     (q_full),
    .push       (push),
    .push_cmd   (push_cmd),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .flush_done (flush_done)
  );

  // Command queue between parser and emitter.
  annb_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head_cmd (head_cmd),
    .empty    (q_empty),
    .full     (q_full)
  );

  // Emitter: one result word per cycle while out_ch takes every word.
  annb_back #(
    .LEAD_BYTES (LEAD_BYTES)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .q_cmd      (head_cmd),
    .pop        (pop),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .flush_done (flush_done),
    .out_ch     (out_ch)
  );

endmodule

// ===== hdl/annb_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// annb_front: start code parser
// Accepts one byte per cycle while the queue has room and no readout runs,
// tracks zero runs and start codes, applies the SEI holdback, queues commands
// for bytes with work; bytes before the first start code fill the lead store.
// ----------------------------------------------------------------------------
module annb_front import annb_pkg::*; #(
  parameter int unsigned LEAD_BYTES = LEAD_BYTES_DEF,
  localparam int unsigned LEAD_CW   = $clog2(LEAD_BYTES + 1),
  localparam int unsigned LEAD_AW   = $clog2(LEAD_BYTES)
) (
  input  logic               clk,
  input  logic               rst,
  annb_in_if.sink            in_ch,
  input  logic               q_full,
  output logic               push,
  output cmd_t               push_cmd,
  output logic               wr_en,
  output logic [LEAD_AW-1:0] wr_addr,
  output logic [7:0]         wr_data,
  input  logic               flush_done
);

  // Parser state.
  logic [1:0]         la_cnt;
  head_t              head;
  logic               scs;
  logic [LEAD_CW-1:0] lead_cnt;
  logic               lead_ovf;
  logic               flush_busy;

  // Step results.
  logic               accept;
  logic               is_zero;
  logic               is_sc;
  logic [1:0]         la_next;
  logic               scs_next;
  logic [LEAD_CW-1:0] lead_cnt_next;
  logic               lead_ovf_next;
  logic [SLOT_W-1:0]  zc;
  logic               commit_b;
  logic               do_end;
  logic               flush;
  head_t              h;
  commit_t            cm;
  res_t [RES_SLOTS-1:0] rs;
  logic [SLOT_W-1:0]  n;

  // Hold off while the queue is full or the leading store is being read out.
  assign in_ch.ready = !q_full && !flush_busy;
  assign accept      = in_ch.valid && in_ch.ready;

  assign is_zero = (in_ch.data_byte == 8'd0);
  assign is_sc   = (in_ch.data_byte == 8'd1) && (la_cnt >= 2'd2);

  assign wr_addr = lead_cnt[LEAD_AW-1:0];
  assign wr_data = in_ch.data_byte;

  // Classify the byte and run the held-back head through its commits.
  always_comb begin
    la_next       = la_cnt;
    scs_next      = scs;
    lead_cnt_next = lead_cnt;
    lead_ovf_next = lead_ovf;
    wr_en         = 1'b0;
    zc            = '0;
    commit_b      = 1'b0;
    do_end        = 1'b0;
    flush         = 1'b0;
    h             = head;
    cm            = '0;
    rs            = '0;
    n             = '0;

    if (!scs) begin
      // Leading region: store the byte while room is left and look for the first start code.
      if (lead_cnt < LEAD_CW'(LEAD_BYTES)) begin
        wr_en         = accept;
        lead_cnt_next = lead_cnt + LEAD_CW'(1);
      end else begin
        lead_ovf_next = 1'b1;
      end
      if (is_zero) begin
        if (la_cnt != 2'd3) begin
          la_next = la_cnt + 2'd1;
        end
      end else if (is_sc) begin
        scs_next      = 1'b1;
        lead_cnt_next = '0;
        lead_ovf_next = 1'b0;
        la_next       = 2'd0;
      end else begin
        la_next = 2'd0;
      end
      if (in_ch.end_of_buffer && !scs_next) begin
        flush = 1'b1;
      end
    end else begin
      // Inside NAL units: zeros wait in case they open a start code.
      if (is_zero) begin
        if (la_cnt == 2'd3) begin
          zc = SLOT_W'(1);
        end else begin
          la_next = la_cnt + 2'd1;
        end
        if (in_ch.end_of_buffer) begin
          zc = zc + SLOT_W'(la_next);
        end
      end else if (is_sc) begin
        la_next = 2'd0;
        do_end  = 1'b1;
      end else begin
        zc       = SLOT_W'(la_cnt);
        commit_b = 1'b1;
        la_next  = 2'd0;
      end
      if (in_ch.end_of_buffer) begin
        do_end = 1'b1;
      end
    end

    // Committed zeros first, then the byte itself.
    for (int k = 0; k < 4; k++) begin
      if (SLOT_W'(k) < zc || (SLOT_W'(k) == zc && commit_b)) begin
        cm = head_commit(h, (SLOT_W'(k) < zc) ? 8'd0 : in_ch.data_byte);
        h  = cm.h;
        if (cm.n != 2'd0) begin
          rs[n] = cm.r0;
          n     = n + SLOT_W'(1);
        end
        if (cm.n == 2'd2) begin
          rs[n] = cm.r1;
          n     = n + SLOT_W'(1);
        end
      end
    end

    // Close the unit on a start code or at the end of the buffer.
    if (do_end) begin
      cm = head_end(h);
      h  = cm.h;
      if (cm.n != 2'd0) begin
        rs[n] = cm.r0;
        n     = n + SLOT_W'(1);
      end
      if (cm.n == 2'd2) begin
        rs[n] = cm.r1;
        n     = n + SLOT_W'(1);
      end
    end
  end

  // Command word for the emitter.
  always_comb begin
    push           = accept && (n != '0 || flush);
    push_cmd.tag   = in_ch.frame_tag;
    push_cmd.n     = n;
    push_cmd.slots = rs;
    push_cmd.flush = flush;
    push_cmd.fcnt  = LEAD_CNT_W'(lead_cnt_next);
    push_cmd.fovf  = lead_ovf_next;
  end

  // State update; all but the readout flag reset after the last buffer byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      la_cnt     <= 2'd0;
      head       <= '0;
      scs        <= 1'b0;
      lead_cnt   <= '0;
      lead_ovf   <= 1'b0;
      flush_busy <= 1'b0;
    end else begin
      if (accept) begin
        if (in_ch.end_of_buffer) begin
          la_cnt   <= 2'd0;
          head     <= '0;
          scs      <= 1'b0;
          lead_cnt <= '0;
          lead_ovf <= 1'b0;
        end else begin
          la_cnt   <= la_next;
          head     <= h;
          scs      <= scs_next;
          lead_cnt <= lead_cnt_next;
          lead_ovf <= lead_ovf_next;
        end
      end
      if (accept && flush) begin
        flush_busy <= 1'b1;
      end else if (flush_done) begin
        flush_busy <= 1'b0;
      end
    end
  end

endmodule

// ===== hdl/annb_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// annb_queue: command queue
// Short first-in first-out buffer of command words between the parser and
// the emitter, so that each side can stall on its own.
// ----------------------------------------------------------------------------
module annb_queue import annb_pkg::*; #(
  localparam int unsigned PTR_W = $clog2(QDEPTH),
  localparam int unsigned CNT_W = $clog2(QDEPTH + 1)
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output cmd_t head_cmd,
  output logic empty,
  output logic full
);

  cmd_t             entries [QDEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign empty    = (count == '0);
  assign full     = (count == CNT_W'(QDEPTH));
  assign head_cmd = entries[rd_ptr];

  // Storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// ===== hdl/annb_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// annb_back: result emitter
// Pops command words and sends their result bytes one per cycle, while the
// receiver takes them, through a registered output stage. Owns the leading
// store and reads it out when a buffer ends without any start code.
// ----------------------------------------------------------------------------
module annb_back import annb_pkg::*; #(
  parameter int unsigned LEAD_BYTES = LEAD_BYTES_DEF,
  localparam int unsigned LEAD_AW   = $clog2(LEAD_BYTES)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_empty,
  input  cmd_t               q_cmd,
  output logic               pop,
  input  logic               wr_en,
  input  logic [LEAD_AW-1:0] wr_addr,
  input  logic [7:0]         wr_data,
  output logic               flush_done,
  annb_out_if.source         out_ch
);

  logic [7:0]         lead_mem [LEAD_BYTES];
  logic [7:0]         rd_data;

  back_state_t        state;
  back_state_t        state_next;
  cmd_t               cmd;
  cmd_t               cmd_next;
  logic [SLOT_W-1:0]  pos;
  logic [SLOT_W-1:0]  pos_next;
  logic [LEAD_AW-1:0] idx;
  logic [LEAD_AW-1:0] idx_next;

  logic               out_load;
  logic               emit;
  logic               done;
  res_t               cur;
  logic               cur_end;
  logic               cur_ovf;

  // Output register.
  logic               out_valid;
  res_t               out_res;
  logic [31:0]        out_frame;
  logic               out_ovf;
  logic               out_step_last;

  assign out_load = !out_valid || out_ch.ready;

  // Leading store: written by the parser, read one byte ahead.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      lead_mem[wr_addr] <= wr_data;
    end
    rd_data <= lead_mem[idx_next];
  end

  // Select the current byte and step through the command.
  always_comb begin
    cur        = '0;
    cur_end    = 1'b0;
    cur_ovf    = 1'b0;
    state_next = state;
    cmd_next   = cmd;
    pos_next   = pos;
    idx_next   = idx;

    case (state)
      BK_SLOTS: begin
        cur     = cmd.slots[pos];
        cur_end = (pos == cmd.n - SLOT_W'(1));
      end
      BK_FLUSH: begin
        cur.data  = rd_data;
        cur.first = (idx == '0);
        cur_end   = ((LEAD_CNT_W'(idx) + LEAD_CNT_W'(1)) == cmd.fcnt);
        cur.last  = cur_end;
        cur_ovf   = cmd.fovf;
      end
      default: begin
        cur = '0;
      end
    endcase

    emit       = (state != BK_IDLE) && out_load;
    done       = emit && cur_end;
    pop        = !q_empty && (state == BK_IDLE || done);
    flush_done = done && (state == BK_FLUSH);

    if (pop) begin
      state_next = q_cmd.flush ? BK_FLUSH : BK_SLOTS;
      cmd_next   = q_cmd;
      pos_next   = '0;
      idx_next   = '0;
    end else if (done) begin
      state_next = BK_IDLE;
      pos_next   = '0;
      idx_next   = '0;
    end else if (emit) begin
      pos_next = pos + SLOT_W'(1);
      idx_next = idx + LEAD_AW'(1);
    end
  end

  // Sequencer registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
      pos   <= '0;
      idx   <= '0;
    end else begin
      state <= state_next;
      pos   <= pos_next;
      idx   <= idx_next;
    end
    cmd <= cmd_next;
  end

  // Output stage: loads a byte from the sequencer whenever it is empty or being taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
    if (emit) begin
      out_res       <= cur;
      out_frame     <= cmd.tag;
      out_ovf       <= cur_ovf;
      out_step_last <= cur_end;
    end
  end

  assign out_ch.valid         = out_valid;
  assign out_ch.nal_byte      = out_res.data;
  assign out_ch.nal_first     = out_res.first;
  assign out_ch.nal_last      = out_res.last;
  assign out_ch.nal_frame     = out_frame;
  assign out_ch.lead_overflow = out_ovf;
  assign out_ch.step_last     = out_step_last;

endmodule
